// ----- rtl/multi_motor_pid_speed_loop_assert.svh -----
// Assertion macros for the multi-motor PID speed loop.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message.
`ifndef MULTI_MOTOR_PID_SPEED_LOOP_ASSERT_SVH
`define MULTI_MOTOR_PID_SPEED_LOOP_ASSERT_SVH

`ifndef SYNTH

`define MMPID_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`define MMPID_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MMPID_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define MMPID_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/mmpid_pkg.sv -----
`default_nettype none

package mmpid_pkg;

  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int RATE_W      = 10;
  localparam int SUM_W       = 48;
  localparam int SUM_SPLIT   = 24;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 82;
  localparam int INC_W       = 35;
  localparam int FRAC_W      = 16;
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = 3 * DATA_W;

  localparam logic [RATE_W-1:0] RATE_RESET = 10'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP   = 2'd0,
    REG_KI   = 2'd1,
    REG_KD   = 2'd2,
    REG_RATE = 2'd3
  } cfg_reg_t;

  // One memory word holds the whole loop state of a motor.
  typedef struct packed {
    logic signed [DATA_W-1:0] duty;
    logic signed [SUM_W-1:0]  esum;
    logic signed [DATA_W-1:0] perr;
    logic        [DATA_W-1:0] pcount;
  } motor_state_t;

  localparam int STATE_W = $bits(motor_state_t);

endpackage

`default_nettype wire

// ----- rtl/mmpid_ram.sv -----
`default_nettype none

module mmpid_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mmpid_mul.sv -----
`default_nettype none

// Shared signed multiplier with a registered product.
module mmpid_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [mmpid_pkg::MUL_W-1:0]  a,
  input  wire logic signed [mmpid_pkg::MUL_W-1:0]  b,
  output logic      signed [mmpid_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_motor_pid_speed_loop.sv -----
`default_nettype none

// Incremental PID speed loop for up to MOTOR_COUNT motors, one request per control tick.
// A request carries the motor index in in_tuser and the encoder count and target speed in
// in_tdata; the result returns the motor index, the measured speed, the error and the new
// duty. Per-motor state lives in one memory word that is read on acceptance and written
// back when the result is loaded. A request for a valid motor passes through one memory read,
// five products in turn on the shared 33 by 33 multiplier, accumulation, truncation and the
// duty update, and the next request is taken the cycle after the result is loaded. A request
// whose motor index is not below MOTOR_COUNT changes nothing and goes straight from acceptance
// to the duty update, where it returns zeros. A new request is accepted while an earlier
// result still waits on out_tready; it then holds at the duty update until the output
// register is free. Gains and rate may only be written while no request is in flight.
module multi_motor_pid_speed_loop #(
  parameter int MOTOR_COUNT = 2
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // Configuration write port.
  input  wire logic                                    cfg_wr_en,
  input  wire logic [mmpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mmpid_pkg::DATA_W-1:0]            cfg_wdata,
  // Request channel.
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [mmpid_pkg::IN_TDATA_W-1:0]        in_tdata,  // encoder_count, target_speed
  input  wire logic                                    in_tuser,  // motor_index
  // Result channel.
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic [mmpid_pkg::OUT_TDATA_W-1:0]            out_tdata, // measured_speed,
                                                                   // speed_error, duty_command
  output logic                                         out_tuser  // duty_motor
);

  `include "multi_motor_pid_speed_loop_assert.svh"

  localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int DW = mmpid_pkg::DATA_W;
  localparam int MW = mmpid_pkg::MUL_W;
  localparam int PW = mmpid_pkg::PROD_W;
  localparam int AC = mmpid_pkg::ACC_W;
  localparam int SW = mmpid_pkg::SUM_W;
  localparam int SP = mmpid_pkg::SUM_SPLIT;
  localparam int IW = mmpid_pkg::INC_W;

  localparam logic signed [PW-1:0] S32_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] S32_MIN = -PW'(64'sd2147483648);
  localparam logic signed [AC-1:0] INC_LIM = AC'(64'sd8589934592);
  localparam logic signed [SW-1:0] S48_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S48_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MRATE, S_SPEED, S_ERR, S_MKP, S_MKD,
    S_MKIL, S_MKIH, S_ACC, S_INC, S_DUTY
  } state_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[DW-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [DW-1:0]                kp_r, ki_r, kd_r;
  logic        [mmpid_pkg::RATE_W-1:0] rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      rate_r <= mmpid_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      unique case (mmpid_pkg::cfg_reg_t'(cfg_index))
        mmpid_pkg::REG_KP:   kp_r   <= cfg_wdata;
        mmpid_pkg::REG_KI:   ki_r   <= cfg_wdata;
        mmpid_pkg::REG_KD:   kd_r   <= cfg_wdata;
        mmpid_pkg::REG_RATE: rate_r <= cfg_wdata[mmpid_pkg::RATE_W-1:0];
      endcase
    end
  end

  state_t                          state_r;
  logic                            idx_r;
  logic [AW-1:0]                   addr_r;
  logic                            bad_r;
  logic [DW-1:0]                   cnt_r;
  logic signed [DW-1:0]            tgt_r;
  mmpid_pkg::motor_state_t         st_r;
  logic signed [DW-1:0]            diff_r;
  logic signed [DW-1:0]            speed_r;
  logic signed [DW-1:0]            err_r;
  logic signed [SW-1:0]            sum_r;
  logic signed [DW:0]              dif_r;
  logic signed [AC-1:0]            acc_r;
  logic signed [IW-1:0]            inc_r;
  logic                            out_valid_r;
  logic [mmpid_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            out_user_r;
  logic [MOTOR_COUNT-1:0]          valid_r;

  logic                            accept;
  logic                            in_range;
  logic                            out_free;
  logic                            out_load;
  logic                            ram_re, ram_we;
  logic [mmpid_pkg::STATE_W-1:0]   ram_rdata;
  mmpid_pkg::motor_state_t         st_load;
  mmpid_pkg::motor_state_t         st_wr;
  logic                            mul_en;
  logic signed [MW-1:0]            mul_a, mul_b;
  logic signed [PW-1:0]            prod;
  logic signed [AC-1:0]            prod_ext, prod_hi_ext;
  logic signed [DW-1:0]            speed_nxt, err_nxt, duty_nxt;
  logic signed [DW:0]              err_diff, dif_nxt;
  logic signed [SW:0]              sum_wide;
  logic signed [SW-1:0]            sum_nxt;
  logic signed [AC-1:0]            acc_adj, quot;
  logic signed [IW-1:0]            inc_nxt;
  logic signed [IW:0]              duty_wide;

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_range  = (int'(in_tuser) < MOTOR_COUNT);
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_DUTY) && out_free;
  assign ram_re    = accept && in_range;
  assign ram_we    = out_load && !bad_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A motor that was never written back reads as all-zero state.
  assign st_load = valid_r[addr_r] ? mmpid_pkg::motor_state_t'(ram_rdata) : '0;

  always_comb begin
    st_wr        = st_r;
    st_wr.pcount = cnt_r;
    st_wr.perr   = err_r;
    st_wr.esum   = sum_r;
    st_wr.duty   = duty_nxt;
  end

  mmpid_ram #(
    .WIDTH (mmpid_pkg::STATE_W),
    .DEPTH (MOTOR_COUNT),
    .AW    (AW)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (addr_r),
    .wdata   (st_wr),
    .re      (ram_re),
    .raddr   (AW'(in_tuser)),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  // Operand selection for the shared multiplier; the product is registered and used in the state after.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_MRATE: begin
        mul_a = {diff_r[DW-1], diff_r};
        mul_b = {{(MW-mmpid_pkg::RATE_W){1'b0}}, rate_r};
      end
      S_MKP: begin
        mul_a = {kp_r[DW-1], kp_r};
        mul_b = {err_r[DW-1], err_r};
      end
      S_MKD: begin
        mul_a = {kd_r[DW-1], kd_r};
        mul_b = dif_r;
      end
      S_MKIL: begin
        mul_a = {ki_r[DW-1], ki_r};
        mul_b = {{(MW-SP){1'b0}}, sum_r[SP-1:0]};
      end
      S_MKIH: begin
        mul_a = {ki_r[DW-1], ki_r};
        mul_b = {{(MW-(SW-SP)){sum_r[SW-1]}}, sum_r[SW-1:SP]};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mmpid_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // Datapath next values.
  always_comb begin
    speed_nxt   = sat32(prod);
    err_diff    = {speed_r[DW-1], speed_r} - {tgt_r[DW-1], tgt_r};
    err_nxt     = sat32({{(PW-DW-1){err_diff[DW]}}, err_diff});
    sum_wide    = {st_r.esum[SW-1], st_r.esum} + {{(SW-DW+1){err_r[DW-1]}}, err_r};
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_nxt = sum_wide[SW] ? S48_MIN : S48_MAX;
    end else begin
      sum_nxt = sum_wide[SW-1:0];
    end
    dif_nxt     = {err_r[DW-1], err_r} - {st_r.perr[DW-1], st_r.perr};
    prod_ext    = {{(AC-PW){prod[PW-1]}}, prod};
    // The upper integral product is small enough to fit after the shift.
    prod_hi_ext = {prod[AC-SP-1:0], {SP{1'b0}}};
    // Truncation toward zero of the Q66.16 sum.
    acc_adj     = acc_r + (acc_r[AC-1] ? AC'({mmpid_pkg::FRAC_W{1'b1}}) : '0);
    quot        = acc_adj >>> mmpid_pkg::FRAC_W;
    if (quot > INC_LIM) begin
      inc_nxt = INC_LIM[IW-1:0];
    end else if (quot < -INC_LIM) begin
      inc_nxt = -INC_LIM[IW-1:0];
    end else begin
      inc_nxt = quot[IW-1:0];
    end
    duty_wide   = {{(IW-DW+1){st_r.duty[DW-1]}}, st_r.duty} + {inc_r[IW-1], inc_r};
    duty_nxt    = sat32({{(PW-IW-1){duty_wide[IW]}}, duty_wide});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= in_tuser;
            addr_r  <= AW'(in_tuser);
            bad_r   <= !in_range;
            cnt_r   <= in_tdata[DW-1:0];
            tgt_r   <= in_tdata[2*DW-1:DW];
            state_r <= in_range ? S_LOAD : S_DUTY;
          end
        end
        S_LOAD: begin
          st_r    <= st_load;
          diff_r  <= cnt_r - st_load.pcount;
          state_r <= S_MRATE;
        end
        S_MRATE: begin
          state_r <= S_SPEED;
        end
        S_SPEED: begin
          speed_r <= speed_nxt;
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r   <= err_nxt;
          state_r <= S_MKP;
        end
        S_MKP: begin
          sum_r   <= sum_nxt;
          dif_r   <= dif_nxt;
          state_r <= S_MKD;
        end
        S_MKD: begin
          acc_r   <= prod_ext;
          state_r <= S_MKIL;
        end
        S_MKIL: begin
          acc_r   <= acc_r + prod_ext;
          state_r <= S_MKIH;
        end
        S_MKIH: begin
          acc_r   <= acc_r + prod_ext;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + prod_hi_ext;
          state_r <= S_INC;
        end
        S_INC: begin
          inc_r   <= inc_nxt;
          state_r <= S_DUTY;
        end
        S_DUTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_user_r  <= idx_r;
            out_data_r  <= bad_r ? '0 : {duty_nxt, err_r, speed_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `MMPID_ASSERT_NXT(a_accept_next, clk, rst_n, accept,
                    (state_r == S_LOAD) || (state_r == S_DUTY),
                    "accepted request did not start processing")
  `MMPID_ASSERT_NXT(a_one_at_a_time, clk, rst_n, accept, !in_tready,
                    "second request taken while one is in flight")
  `MMPID_ASSERT_IMP(a_result_source, clk, rst_n, $rose(out_valid_r),
                    $past(state_r == S_DUTY), "result appeared outside the duty update")
  `MMPID_ASSERT_NXT(a_read_then_load, clk, rst_n, ram_re, state_r == S_LOAD,
                    "state read not followed by load")
  `MMPID_ASSERT_IMP(a_bad_index_zero, clk, rst_n,
                    out_tvalid && (int'(out_tuser) >= MOTOR_COUNT), out_tdata == '0,
                    "out-of-range motor returned non-zero result")

endmodule

`default_nettype wire
